[rtl/frl_pkg.sv]
// Package for the fixed-window rate limiter: field widths, register indexes,
// controller states and the command/status structs. No dependencies.
`default_nettype none
package frl_pkg;

	localparam int TIME_W   = 31;
	localparam int COUNT_W  = 16;
	localparam int UIDX_W   = 8;
	localparam int UIDX_SPAN = 256;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;
	localparam int DIV_STEPS  = TIME_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b1;

	localparam logic [TIME_W-1:0]  WINDOW_SIZE_RST  = 31'd10;
	localparam logic [COUNT_W-1:0] MAX_REQUESTS_RST = 16'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} frl_state_t;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} frl_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} frl_sts_t;

endpackage
`default_nettype wire

[rtl/frl_req_if.sv]
// Request channel of the rate limiter: valid/ready plus user index and time.
// Depends on frl_pkg.
`default_nettype none
interface frl_req_if
	import frl_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [UIDX_W-1:0] user_index;
	logic [TIME_W-1:0] current_time;

	modport source (output valid, output user_index, output current_time, input ready);
	modport sink (input valid, input user_index, input current_time, output ready);
endinterface
`default_nettype wire

[rtl/frl_resp_if.sv]
// Response channel of the rate limiter: valid/ready plus the allowed flag.
// No dependencies.
`default_nettype none
interface frl_resp_if;
	logic valid;
	logic ready;
	logic allowed;

	modport source (output valid, output allowed, input ready);
	modport sink (input valid, input allowed, output ready);
endinterface
`default_nettype wire

[rtl/fixed_window_rate_limiter_core.sv]
// Top level of the fixed-window rate limiter: controller plus datapath.
// Depends on frl_pkg, frl_req_if, frl_resp_if, frl_ctrl, frl_dp.
//
//  channel | dir | beat payload                 | handshake
//  --------+-----+------------------------------+------------------
//  req     | in  | user_index[7:0], time[30:0]  | valid/ready
//  resp    | out | allowed                      | valid/ready
//  cfg     | in  | cfg_index[0], cfg_data[30:0] | cfg_we, no stall
//
// A request is accepted, then passes the bit-serial remainder unit (one time
// bit per cycle against the window size), then updates the user table and
// loads the result register; no new request is accepted before that.
// Reset (arst_n low) clears all entry valid bits at once and loads the
// register defaults (max 3, window 10); no clearing pass.
// A response beat waiting on resp.ready does not block the next request; only
// its commit waits until the result register is free.
`default_nettype none
module fixed_window_rate_limiter_core
	import frl_pkg::*;
#(
	parameter int USERS = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	frl_req_if.sink                    req,
	frl_resp_if.source                 resp
);

	frl_cmd_t cmd;
	frl_sts_t sts;

	// sequencer: idle -> divide -> commit
	frl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// remainder unit, table and result register
	frl_dp #(
		.USERS (USERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.user_index   (req.user_index),
		.current_time (req.current_time),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (resp.valid),
		.out_ready    (resp.ready),
		.out_allowed  (resp.allowed)
	);

endmodule
`default_nettype wire

[rtl/frl_ctrl.sv]
// Sequencer for the rate limiter: accept, divide, commit.
// Depends on frl_pkg.
`default_nettype none
module frl_ctrl
	import frl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire frl_sts_t sts,
	output frl_cmd_t      cmd
);

	frl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/frl_dp.sv]
// Datapath of the rate limiter: config registers, restoring remainder unit,
// per-user table (memory + valid bits) and the output register. Uses frl_pkg.
`default_nettype none
module frl_dp
	import frl_pkg::*;
#(
	parameter int USERS = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [UIDX_W-1:0]     user_index,
	input  wire logic [TIME_W-1:0]     current_time,
	input  wire frl_cmd_t              cmd,
	output frl_sts_t                   sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_allowed
);

	localparam int DEPTH   = (USERS < UIDX_SPAN) ? USERS : UIDX_SPAN;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENTRY_W = TIME_W + COUNT_W;

	logic [COUNT_W-1:0] max_req_q;
	logic [TIME_W-1:0]  win_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q  <= MAX_REQUESTS_RST;
			win_size_q <= WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_REQUESTS: max_req_q  <= cfg_data[COUNT_W-1:0];
				REG_WINDOW_SIZE:  win_size_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// user_index modulo USERS, folded at elaboration
	logic [IDX_W-1:0] idx_lut [UIDX_SPAN];
	for (genvar v = 0; v < UIDX_SPAN; v++) begin : g_lut
		assign idx_lut[v] = IDX_W'(v % USERS);
	end

	logic [IDX_W-1:0]   idx_q;
	logic [TIME_W-1:0]  time_q;
	logic [TIME_W-1:0]  tsh_q;
	logic [TIME_W-1:0]  div_q;
	logic [TIME_W-1:0]  rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [TIME_W:0]    rem_sh;
	logic [TIME_W:0]    rem_sub;

	assign rem_sh  = {rem_q, tsh_q[TIME_W-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q  <= idx_lut[user_index];
			time_q <= current_time;
			tsh_q  <= current_time;
			div_q  <= (win_size_q == '0) ? TIME_W'(1) : win_size_q;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.step) begin
			tsh_q  <= {tsh_q[TIME_W-2:0], 1'b0};
			rem_q  <= rem_sub[TIME_W] ? rem_sh[TIME_W-1:0] : rem_sub[TIME_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
	end

	assign sts.div_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.out_free = !out_valid || out_ready;

	// table: {window begin, count}, registered read at the latched index
	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [DEPTH-1:0]   valid_q;
	logic [ENTRY_W-1:0] wr_data;
	logic               wr_en;
	logic               allow;
	logic [TIME_W-1:0]  begin_new;
	logic [TIME_W-1:0]  begin_old;
	logic [COUNT_W-1:0] count_old;
	logic               hit;

	assign begin_new = time_q - rem_q;
	assign begin_old = rd_q[ENTRY_W-1:COUNT_W];
	assign count_old = rd_q[COUNT_W-1:0];
	assign hit       = valid_q[idx_q] && (begin_old == begin_new);

	always_comb begin
		wr_en   = 1'b0;
		allow   = 1'b1;
		wr_data = {begin_new, COUNT_W'(1)};
		if (!hit) begin
			wr_en = cmd.commit;
		end else if (count_old >= max_req_q) begin
			allow = 1'b0;
		end else begin
			// count < max <= all ones, so no overflow here
			wr_en   = cmd.commit;
			wr_data = {begin_old, count_old + COUNT_W'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_q] <= wr_data;
		end
		rd_q <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_allowed <= allow;
		end
	end

endmodule
`default_nettype wire

[tb/frl_verdict_checker.sv]
// Scoreboard for the rate limiter: tracks register writes, predicts allow/block
// per request beat and compares each response beat in order.
// Depends on frl_pkg, frl_req_if, frl_resp_if.
`timescale 1ns / 1ps
module frl_verdict_checker
	import frl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	frl_req_if                    req,
	frl_resp_if                   resp,
	output int unsigned           fail_count,
	output int unsigned           outstanding,
	output int unsigned           blocked_count
);

	logic               seen      [UIDX_SPAN];
	logic [TIME_W-1:0]  win_start [UIDX_SPAN];
	logic [COUNT_W-1:0] hits      [UIDX_SPAN];
	logic [COUNT_W-1:0] cap;
	logic [TIME_W-1:0]  span;
	logic               verdicts_due [$];

	// Updates the per-user window table and returns 1 for allow, 0 for block.
	function automatic logic judge_request(input logic [UIDX_W-1:0] user,
			input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] unit_len;
		logic [TIME_W-1:0] start_t;
		int unsigned       slot;
		slot     = int'(user) % UIDX_SPAN;
		unit_len = (span == '0) ? TIME_W'(1) : span;   // zero window acts as one
		start_t  = (stamp / unit_len) * unit_len;
		if (!seen[slot] || win_start[slot] != start_t) begin
			seen[slot]      = 1'b1;
			win_start[slot] = start_t;
			hits[slot]      = COUNT_W'(1);
			return 1'b1;
		end
		if (hits[slot] >= cap)
			return 1'b0;
		if (hits[slot] != '1)
			hits[slot] = hits[slot] + COUNT_W'(1);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			for (int i = 0; i < UIDX_SPAN; i++)
				seen[i] = 1'b0;
			cap  = MAX_REQUESTS_RST;
			span = WINDOW_SIZE_RST;
			verdicts_due.delete();
			fail_count    = 0;
			blocked_count = 0;
			outstanding  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_REQUESTS: cap  = cfg_data[COUNT_W-1:0];
					REG_WINDOW_SIZE:  span = cfg_data[TIME_W-1:0];
					default: ;
				endcase
			end
			// response first: a beat with an empty queue is flagged before
			// a request on the same edge can hide it
			if (resp.valid && resp.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("allowed: unexpected beat, expected none, actual %0b",
						resp.allowed);
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (resp.allowed !== want) begin
						$error("allowed: expected %0b, actual %0b", want, resp.allowed);
						fail_count++;
					end else if (!want) begin
						blocked_count++;
					end
				end
			end
			if (req.valid && req.ready)
				verdicts_due.push_back(judge_request(req.user_index, req.current_time));
			outstanding <= verdicts_due.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the rate limiter testbench: clock, reset, request/response stimulus
// and the verdict. Depends on frl_pkg, frl_req_if, frl_resp_if,
// fixed_window_rate_limiter_core and frl_verdict_checker.
`timescale 1ns / 1ps
module testbench
	import frl_pkg::*;
;

	localparam int PHASES      = 8;
	localparam int PER_PHASE   = 193;   // random beats per register setting
	localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side
	localparam int SETTLE      = 40;    // idle cycles after the final drain

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned blocked_count;
	int unsigned sent          = 0;
	int unsigned quiet         = 0;
	int unsigned send_idle_pct = 20;
	int unsigned recv_idle_pct = 67;

	frl_req_if  req_ch ();
	frl_resp_if resp_ch ();

	fixed_window_rate_limiter_core #(.USERS(UIDX_SPAN)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.resp      (resp_ch)
	);

	frl_verdict_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req           (req_ch),
		.resp          (resp_ch),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.blocked_count (blocked_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Response back-pressure: fresh coin per cycle, driven at the edge.
	initial begin
		resp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			resp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: the block answers every request once the response side
	// takes beats, so a long silent stretch means a hang.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready)) begin
			quiet <= 0;
		end else if (quiet == STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// One request beat, with an optional random gap in front of it. Valid is
	// only lowered when a gap is taken, so back-to-back beats keep it high.
	task automatic send_req(input logic [UIDX_W-1:0] user, input logic [TIME_W-1:0] stamp);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_ch.valid        <= 1'b1;
		req_ch.user_index   <= user;
		req_ch.current_time <= stamp;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// Stop sending and wait until every predicted verdict has come back.
	// The first edge lets the scoreboard count a beat taken on this edge.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [UIDX_W-1:0]  hot [3];
		logic [UIDX_W-1:0]  user;
		logic [TIME_W-1:0]  base_time;
		logic [TIME_W-1:0]  span;
		logic [TIME_W-1:0]  unit_len;
		logic [TIME_W-1:0]  stamp;
		logic [COUNT_W-1:0] cap;
		logic [31:0]        boundary;
		int unsigned        pick;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_MAX_REQUESTS;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.user_index   = '0;
		req_ch.current_time = '0;
		base_time           = '0;
		span                = WINDOW_SIZE_RST;
		cap                 = MAX_REQUESTS_RST;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset settings (max 3, window 10).
		// User 0: fill window [0,10) to the limit, then a block.
		send_req(8'd0, 31'd0);
		send_req(8'd0, 31'd9);
		send_req(8'd0, 31'd5);
		send_req(8'd0, 31'd1);               // fourth in window -> blocked
		send_req(8'd0, 31'd10);              // next window reloads the entry
		send_req(8'd0, 31'd3);               // going back in time is a new window too
		// User 255 at the top of the time range: last window starts at
		// 2147483640, so the 4th hit there blocks.
		send_req(8'd255, 31'h7FFF_FFFF);
		send_req(8'd255, 31'd2147483640);
		send_req(8'd255, 31'h7FFF_FFFE);
		send_req(8'd255, 31'd2147483641);
		// Alternating bit patterns on both fields.
		send_req(8'hAA, 31'h2AAA_AAAA);
		send_req(8'h55, 31'h5555_5555);

		for (int ph = 0; ph < PHASES; ph++) begin
			// idle mix: receiver-heavy gaps, then sender-heavy, then none
			case (ph * 3 / PHASES)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			case (ph)
				0: begin
					cap  = MAX_REQUESTS_RST;
					span = WINDOW_SIZE_RST;
				end
				1: begin                      // zero maximum, shortest window
					cap  = 16'd0;
					span = 31'd1;
				end
				2: begin                      // largest limit and window
					cap  = 16'hFFFF;
					span = 31'h7FFF_FFFF;
				end
				3: begin                      // zero window behaves as one
					cap  = 16'd1;
					span = 31'd0;
				end
				4: begin
					cap  = 16'd2;
					span = 31'd7;
				end
				5: begin
					cap  = COUNT_W'($urandom_range(1, 6));
					span = TIME_W'($urandom_range(1, 4096));
				end
				6: begin
					cap  = COUNT_W'($urandom_range(1, 10));
					span = TIME_W'($urandom_range(1, 32'h7FFF_FFFF));
				end
				default: begin
					cap  = 16'd4;
					span = 31'd1000;
				end
			endcase

			// registers only change with the pipe empty; phase 0 keeps reset values
			if (ph != 0) begin
				drain();
				write_reg(REG_MAX_REQUESTS, CFG_DATA_W'(cap));
				write_reg(REG_WINDOW_SIZE, span);
			end

			// A few hot users hammer a slowly moving clock so entries hit
			// their limit; the rest is random users and random times.
			for (int i = 0; i < 3; i++)
				hot[i] = UIDX_W'($urandom_range(0, 255));
			base_time = TIME_W'($urandom());
			unit_len  = (span == '0) ? TIME_W'(1) : span;

			for (int n = 0; n < PER_PHASE; n++) begin
				if ($urandom_range(0, 7) == 0)
					base_time = base_time + TIME_W'($urandom_range(0, 32'(unit_len) / 2 + 1));
				user = ($urandom_range(0, 99) < 75) ? hot[$urandom_range(0, 2)]
					: UIDX_W'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					stamp = base_time + TIME_W'($urandom_range(0, 3));
				end else if (pick < 85) begin
					// straddle the next window edge
					boundary = (32'(base_time) / 32'(unit_len) + 1) * 32'(unit_len);
					stamp    = TIME_W'(boundary - $urandom_range(0, 1));
				end else begin
					stamp = TIME_W'($urandom());
				end
				send_req(user, stamp);
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("Summary: %0d requests over %0d register settings, %0d blocked.",
			sent, PHASES, blocked_count);
		$display("Summary: limits 0..65535, windows 0/1/max, three idle mixes.");
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[fixed_window_rate_limiter_core.f]
rtl/frl_pkg.sv
rtl/frl_req_if.sv
rtl/frl_resp_if.sv
rtl/frl_ctrl.sv
rtl/frl_dp.sv
rtl/fixed_window_rate_limiter_core.sv
tb/frl_verdict_checker.sv
tb/testbench.sv
